### src/ubx_frame_checker_macros.svh
// Assertion macros for the UBX frame checker.
// Each macro takes a label, a clock and a property; UBXFC_ASSERT also takes a reset.
`ifndef UBX_FRAME_CHECKER_MACROS_SVH
`define UBX_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define UBXFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ubx_frame_checker: assertion failed");

// Check a property on every rising edge, reset included.
`define UBXFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("ubx_frame_checker: assertion failed");

`else

`define UBXFC_ASSERT(label, clk, rst, prop)
`define UBXFC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### src/ubxfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ubxfc_pkg;

  // Largest frame buffer downstream; payload limit is this less the frame overhead.
  localparam int unsigned BUFFER_DEPTH = 4096;
  localparam logic [16:0] LEN_CAP      = 17'(BUFFER_DEPTH - 8);

  localparam logic [11:0] MAX_PAYLOAD_RESET = 12'd4088;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  typedef enum logic [2:0] {
    ST_BUSY = 3'd0,
    ST_GOOD = 3'd1,
    ST_SYNC = 3'd2,
    ST_CSUM = 3'd3,
    ST_LONG = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_frame;
    logic       frame_last;
    status_t    status;
    logic       fail_led;
  } result_t;

endpackage

`default_nettype wire

### src/ubxfc_in_slice.sv
`timescale 1ns / 1ps
`default_nettype none

module ubxfc_in_slice
  import ubxfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  input  wire logic [7:0] s_byte,
  input  wire logic       take,
  output logic            valid,
  output logic [7:0]      rx_byte
);

  // Accept when empty or when the held byte moves on this cycle.
  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      rx_byte <= s_byte;
    end
  end

endmodule

`default_nettype wire

### src/ubxfc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ubxfc_parser
  import ubxfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        advance,
  output result_t          result
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  got_sum_a, got_sum_a_next;
  logic        fail_flag, fail_flag_next;
  logic [11:0] max_payload;

  logic [7:0]  add_a, add_b;
  logic [15:0] len_full, count_inc;
  logic        too_long;
  logic        inf;
  status_t     st;

  assign add_a     = sum_a + rx_byte;
  assign add_b     = sum_b + add_a;
  assign len_full  = {rx_byte, payload_length[7:0]};
  assign count_inc = payload_count + 16'd1;
  assign too_long  = (len_full > {4'd0, max_payload}) || ({1'b0, len_full} > LEN_CAP);

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    got_sum_a_next      = got_sum_a;
    fail_flag_next      = fail_flag;
    inf                 = 1'b1;
    st                  = ST_BUSY;
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC_TWO) begin
          sum_a_next = '0;
          sum_b_next = '0;
          phase_next = PH_CLASS;
        end else begin
          inf            = 1'b0;
          st             = ST_SYNC;
          fail_flag_next = 1'b1;
          phase_next     = (rx_byte == SYNC_ONE) ? PH_SYNC2 : PH_HUNT;
        end
      end
      PH_CLASS: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        phase_next = PH_ID;
      end
      PH_ID: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        payload_length_next = {8'd0, rx_byte};
        phase_next          = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        payload_length_next = len_full;
        payload_count_next  = '0;
        if (too_long) begin
          st         = ST_LONG;
          phase_next = PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_next = PH_CK_A;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        payload_count_next = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_CK_A;
        end
      end
      PH_CK_A: begin
        got_sum_a_next = rx_byte;
        phase_next     = PH_CK_B;
      end
      PH_CK_B: begin
        if (got_sum_a == sum_a && rx_byte == sum_b) begin
          st             = ST_GOOD;
          fail_flag_next = 1'b0;
        end else begin
          st = ST_CSUM;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        inf = 1'b0;
        if (rx_byte == SYNC_ONE) begin
          phase_next = PH_SYNC2;
        end else begin
          st             = ST_SYNC;
          fail_flag_next = 1'b1;
          phase_next     = PH_HUNT;
        end
      end
    endcase
  end

  assign result.out_byte   = rx_byte;
  assign result.in_frame   = inf;
  assign result.frame_last = (st != ST_BUSY);
  assign result.status     = st;
  assign result.fail_led   = fail_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      payload_length <= '0;
      payload_count  <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      got_sum_a      <= '0;
      fail_flag      <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      got_sum_a      <= got_sum_a_next;
      fail_flag      <= fail_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

### src/ubxfc_out_slice.sv
`timescale 1ns / 1ps
`default_nettype none

module ubxfc_out_slice
  import ubxfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result_in,
  output logic         can_load,
  output logic         m_valid,
  input  wire logic    m_ready,
  output result_t      result_q
);

  // Room when empty or when the held result leaves this cycle.
  assign can_load = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (can_load) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

`default_nettype wire

### src/ubx_frame_checker.sv
// UBX frame checker: one received byte in, one marked byte out.
// Two registers lie between input request and result: input register, result register.
// Throughput: one byte per cycle while downstream keeps up; framing state and checksums update in one pass.
// Reset (rst, synchronous, active high): hunt for first sync byte, sums and flags
// cleared, max_payload back to 4088, both pipeline registers emptied.
`timescale 1ns / 1ps
`default_nettype none
`include "ubx_frame_checker_macros.svh"

module ubx_frame_checker
  import ubxfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: max_payload register, written whenever cfg_wr_en is high.
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tlast,  // frame_last
  output logic [7:0]       m_axis_tuser   // [0] in_frame, [3:1] status, [4] fail_led, [7:5] 0
);

  logic    in_valid;
  logic [7:0] in_byte;
  logic    can_load;
  logic    advance;
  result_t result;
  result_t result_q;

  // Move a request from the input register into the result register whenever
  // the result register has room; the parser state advances on the same edge.
  assign advance = in_valid && can_load;

  ubxfc_in_slice u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_byte  (s_axis_tdata),
    .take    (advance),
    .valid   (in_valid),
    .rx_byte (in_byte)
  );

  // Framing state machine, running Fletcher sums and length checks.
  ubxfc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx_byte     (in_byte),
    .advance     (advance),
    .result      (result)
  );

  // Hold the finished result until downstream takes it.
  ubxfc_out_slice u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (result),
    .can_load  (can_load),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .result_q  (result_q)
  );

  assign m_axis_tdata = result_q.out_byte;
  assign m_axis_tlast = result_q.frame_last;
  assign m_axis_tuser = {3'b000, result_q.fail_led, result_q.status, result_q.in_frame};

  // A good frame always clears the fail indicator.
  `UBXFC_ASSERT(a_good_clears_fail, clk, rst,
    m_axis_tvalid && result_q.status == ST_GOOD |-> !result_q.fail_led)
  // A sync error sets the fail indicator and is never inside a frame.
  `UBXFC_ASSERT(a_sync_sets_fail, clk, rst,
    m_axis_tvalid && result_q.status == ST_SYNC |-> result_q.fail_led && !result_q.in_frame)
  // Last mark goes exactly with a final status.
  `UBXFC_ASSERT(a_last_matches_status, clk, rst,
    m_axis_tvalid |-> result_q.frame_last == (result_q.status != ST_BUSY))
  // An advance into the result register shows up as valid output next cycle.
  `UBXFC_ASSERT(a_advance_gives_valid, clk, rst, advance |=> m_axis_tvalid)
  // Both pipeline registers come out of reset empty.
  `UBXFC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_axis_tvalid && !in_valid)

endmodule

`default_nettype wire
